### hw/rtl/hashed_timer_wheel_assert.svh
// Assertion macros for the timer wheel checker.
// No dependencies.
`ifndef HASHED_TIMER_WHEEL_ASSERT_SVH
`define HASHED_TIMER_WHEEL_ASSERT_SVH
// implication checked on every clock, off during reset
`define HTW_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define HTW_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

### hw/rtl/htw_pkg.sv
// Shared types and codes for the hashed timer wheel.
// No dependencies.
package htw_pkg;
  // wheel geometry, fixed for the whole design
  localparam int WHEEL_SLOTS = 16;
  localparam int TASKS       = 16;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_QUERY  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO      = 2'd1;
  localparam logic [1:0] ST_NOTPARKED = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LATCH, CMD_TICK_ADV, CMD_WALK_RD, CMD_WALK_DO,
    CMD_INS_RD, CMD_INS_UNL, CMD_INS_APP, CMD_REM, CMD_QRY_RD, CMD_QRY_MUL,
    CMD_QRY_FIN, CMD_EMIT, CMD_DONE_RES
  } cmd_e;

  typedef struct packed {
    logic ok_task;
    logic parked;
    logic node_valid;
    logic node_expire;
    logic out_taken;
    logic steps_done;
    logic dly_zero;
  } stat_t;
endpackage

### hw/rtl/htw_datapath.sv
// Datapath: link tables, slot heads and tails, query arithmetic, output register.
// Depends on htw_pkg.
module htw_datapath import htw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_e        cmd_i,
  input  logic        out_last_i,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  task_req_i,
  input  logic [31:0] delay_ticks_i,
  output stat_t       stat_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        expired_o,
  output logic [3:0]  expired_task_o,
  output logic [31:0] remaining_o,
  output logic        last_o
);
  localparam int SW = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
  localparam int TW = $clog2(TASKS);
  localparam int LW = $clog2(TASKS + 1);
  localparam logic [LW-1:0] NONE = LW'(TASKS);
  localparam int RW = 33;

  logic [SW-1:0] cur_q;
  logic [TASKS-1:0] parked_q;
  logic [SW-1:0] eslot_q [TASKS];
  logic [RW-1:0] eround_q [TASKS];
  logic [LW-1:0] nxt_q [TASKS];
  logic [LW-1:0] prv_q [TASKS];
  logic [LW-1:0] head_q [WHEEL_SLOTS];
  logic [LW-1:0] tail_q [WHEEL_SLOTS];

  logic [1:0]  kind_q;
  logic [3:0]  task_q;
  logic [31:0] dly_q;
  logic [LW-1:0] node_q;
  logic [LW:0] steps_q;
  logic [SW-1:0] es_q;
  logic [RW-1:0] er_q;
  logic [LW-1:0] ep_q, en_q;
  logic [63:0] rem_q;
  logic        nexp_q;
  logic        hit_q;
  logic [TW-1:0] pend_q;

  logic [TW-1:0] ti;
  logic [TW-1:0] ni;
  assign ti = task_q[TW-1:0];
  assign ni = node_q[TW-1:0];

  logic [SW-1:0] ins_slot;
  logic [32:0]   dm1;
  logic [SW-1:0] slot_dist;
  logic [SW:0]   dfull;
  assign ins_slot = SW'({1'b0, 32'(cur_q)} + {1'b0, dly_q});
  assign dm1 = {1'b0, dly_q} - 33'd1;
  assign slot_dist = es_q - cur_q;
  assign dfull = (slot_dist == '0) ? (SW+1)'(WHEEL_SLOTS) : {1'b0, slot_dist};

  logic out_fire;
  assign out_fire = out_valid_o && !out_stall_i;

  assign stat_o.ok_task = ({28'd0, task_q} < 32'(TASKS));
  assign stat_o.parked = parked_q[ti];
  assign stat_o.node_valid = node_q < NONE;
  assign stat_o.node_expire = nexp_q;
  assign stat_o.out_taken = !out_valid_o;
  assign stat_o.steps_done = steps_q >= (LW+1)'(TASKS);
  assign stat_o.dly_zero = (dly_q == '0);

  // final result fields for insert, remove and query
  logic [1:0]  res_status;
  logic [31:0] res_rem;
  always_comb begin
    res_status = ST_OK;
    res_rem = '0;
    if (cmd_i == CMD_DONE_RES) begin
      unique case (kind_q)
        KIND_INSERT: res_status = !stat_o.ok_task ? ST_NOTPARKED :
                                  (dly_q == '0) ? ST_ZERO : ST_OK;
        KIND_REMOVE: res_status = hit_q ? ST_OK : ST_NOTPARKED;
        KIND_QUERY: res_rem = hit_q ?
                    ((rem_q[63:32] != '0) ? 32'hFFFF_FFFF : rem_q[31:0]) : 32'd0;
        default: ;
      endcase
    end
  end

  // unlink uses es_q/ep_q/en_q of the task or node read last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      parked_q <= '0;
      out_valid_o <= 1'b0;
      for (int i = 0; i < WHEEL_SLOTS; i++) begin
        head_q[i] <= NONE;
        tail_q[i] <= NONE;
      end
    end else begin
      if (out_fire) out_valid_o <= 1'b0;
      unique case (cmd_i)
        CMD_LATCH: begin
          kind_q <= kind_i;
          task_q <= task_req_i;
          dly_q  <= delay_ticks_i;
          steps_q <= '0;
        end
        CMD_TICK_ADV: begin
          cur_q <= SW'({1'b0, cur_q} + (SW+1)'(1));
          node_q <= head_q[SW'({1'b0, cur_q} + (SW+1)'(1))];
          steps_q <= '0;
        end
        CMD_WALK_RD: begin
          es_q <= eslot_q[ni];
          ep_q <= prv_q[ni];
          en_q <= nxt_q[ni];
          er_q <= eround_q[ni];
          nexp_q <= (eround_q[ni] == '0);
        end
        CMD_WALK_DO: begin
          if (!nexp_q) eround_q[ni] <= er_q - RW'(1);
          else begin
            if (ep_q < NONE) nxt_q[ep_q[TW-1:0]] <= en_q; else head_q[es_q] <= en_q;
            if (en_q < NONE) prv_q[en_q[TW-1:0]] <= ep_q; else tail_q[es_q] <= ep_q;
            parked_q[ni] <= 1'b0;
            pend_q <= ni;   // held until the next expiry or the end of the walk
          end
          node_q <= en_q;
          steps_q <= steps_q + (LW+1)'(1);
        end
        CMD_INS_RD, CMD_QRY_RD: begin
          es_q <= eslot_q[ti];
          ep_q <= prv_q[ti];
          en_q <= nxt_q[ti];
          er_q <= eround_q[ti];
          hit_q <= stat_o.ok_task && parked_q[ti];
        end
        CMD_INS_UNL, CMD_REM: begin
          if (ep_q < NONE) nxt_q[ep_q[TW-1:0]] <= en_q; else head_q[es_q] <= en_q;
          if (en_q < NONE) prv_q[en_q[TW-1:0]] <= ep_q; else tail_q[es_q] <= ep_q;
          parked_q[ti] <= 1'b0;
          if (cmd_i == CMD_REM) eround_q[ti] <= '0;
        end
        CMD_INS_APP: begin
          prv_q[ti] <= tail_q[ins_slot];
          nxt_q[ti] <= NONE;
          if (tail_q[ins_slot] < NONE) nxt_q[tail_q[ins_slot][TW-1:0]] <= LW'(task_q);
          else head_q[ins_slot] <= LW'(task_q);
          tail_q[ins_slot] <= LW'(task_q);
          eslot_q[ti] <= ins_slot;
          eround_q[ti] <= RW'(dm1 >> SW);
          parked_q[ti] <= 1'b1;
        end
        CMD_QRY_MUL: rem_q <= 64'(er_q) * 64'(WHEEL_SLOTS);
        CMD_QRY_FIN: rem_q <= rem_q + 64'(dfull);
        default: ;
      endcase
      if (cmd_i == CMD_EMIT || cmd_i == CMD_DONE_RES) begin
        out_valid_o <= 1'b1;
        last_o <= out_last_i;
        expired_o <= (cmd_i == CMD_EMIT);
        expired_task_o <= (cmd_i == CMD_EMIT) ? 4'(pend_q) : 4'd0;
        status_o <= res_status;
        remaining_o <= res_rem;
      end
    end
  end
endmodule

### hw/rtl/htw_ctrl.sv
// Controller state machine sequencing the wheel datapath.
// Depends on htw_pkg.
module htw_ctrl import htw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] kind_i,
  input  stat_t      stat_i,
  output cmd_e       cmd_o,
  output logic       out_last_o
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_WRD = 4'd2, S_WDO = 4'd3,
    S_WEMIT = 4'd4, S_INS = 4'd5, S_APP = 4'd6, S_QMUL = 4'd7, S_QFIN = 4'd8,
    S_RES = 4'd9, S_WAIT = 4'd10, S_WNEXT = 4'd11, S_REM = 4'd12;
  logic [3:0] state_q, state_d;
  logic       any_q, any_d;
  logic [1:0] kind_q;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    any_d = any_q;
    cmd_o = CMD_NONE;
    out_last_o = 1'b1;
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o = CMD_LATCH;
        state_d = S_DISP;
      end
      S_DISP: begin
        // wait for the output register to drain before touching state
        if (stat_i.out_taken) begin
          unique case (kind_q)
            KIND_TICK: begin cmd_o = CMD_TICK_ADV; any_d = 1'b0; state_d = S_WNEXT; end
            KIND_INSERT: begin cmd_o = CMD_INS_RD; state_d = S_INS; end
            KIND_REMOVE: begin cmd_o = CMD_INS_RD; state_d = S_REM; end
            default: begin cmd_o = CMD_QRY_RD; state_d = S_QMUL; end
          endcase
        end
      end
      S_WNEXT: begin
        if (stat_i.node_valid && !stat_i.steps_done) begin
          cmd_o = CMD_WALK_RD; state_d = S_WRD;
        end else if (!any_q) state_d = S_RES;
        else state_d = S_WAIT;
      end
      // an expiry is reported when the next one is found or at the end of the walk, so the final one can carry last
      S_WRD: if (stat_i.node_expire && any_q) begin
        if (stat_i.out_taken) begin
          cmd_o = CMD_EMIT; out_last_o = 1'b0; state_d = S_WEMIT;
        end
      end else begin
        cmd_o = CMD_WALK_DO; state_d = S_WNEXT;
        if (stat_i.node_expire) any_d = 1'b1;
      end
      S_WEMIT: begin cmd_o = CMD_WALK_DO; state_d = S_WDO; end
      S_WDO: state_d = S_WNEXT;
      S_WAIT: if (stat_i.out_taken) begin
        cmd_o = CMD_EMIT; state_d = S_IDLE;
      end
      S_INS: begin
        if (stat_i.ok_task && !stat_i.dly_zero && stat_i.parked) cmd_o = CMD_INS_UNL;
        state_d = S_APP;
      end
      S_APP: begin
        state_d = S_RES;
        cmd_o = CMD_INS_APP;
        if (!stat_i.ok_task || stat_i.dly_zero) cmd_o = CMD_NONE;
      end
      S_REM: begin
        if (stat_i.ok_task && stat_i.parked) cmd_o = CMD_REM;
        state_d = S_RES;
      end
      S_QMUL: begin cmd_o = CMD_QRY_MUL; state_d = S_QFIN; end
      S_QFIN: begin cmd_o = CMD_QRY_FIN; state_d = S_RES; end
      S_RES: if (stat_i.out_taken) begin
        cmd_o = CMD_DONE_RES; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      any_q <= 1'b0;
      kind_q <= KIND_TICK;
    end else begin
      state_q <= state_d;
      any_q <= any_d;
      if (cmd_o == CMD_LATCH) kind_q <= kind_i;
    end
  end
endmodule

### hw/rtl/hashed_timer_wheel.sv
// Top level of the hashed timer wheel: controller plus datapath.
// Depends on htw_pkg, htw_ctrl, htw_datapath.
//
//  channel | direction | handshake             | fields
//  in      | input     | in_valid_i/in_stall_o | kind_i task_req_i delay_ticks_i
//  out     | output    | out_valid_o/out_stall_i | status_o expired_o expired_task_o
//          |           |                       | remaining_o last_o
//
// One item at a time. Remove reads and unlinks a parked task; insert also
// appends it to its slot unless the delay is zero; query reads the rounds and
// slot distance. Tick: one slot list walked entry by entry.
// Reset clears the slot heads, tails and parked bits at once; no sweep.
// A stalled output holds the walk; the last result of an item waits in the
// output register while the next item is taken.
module hashed_timer_wheel import htw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  task_req_i,
  input  logic [31:0] delay_ticks_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        expired_o,
  output logic [3:0]  expired_task_o,
  output logic [31:0] remaining_o,
  output logic        last_o
);
  cmd_e  cmd;
  stat_t stat;
  logic  out_last;

  htw_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i,
    .stat_i(stat), .cmd_o(cmd), .out_last_o(out_last)
  );

  htw_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .out_last_i(out_last), .kind_i, .task_req_i,
    .delay_ticks_i, .stat_o(stat), .out_valid_o, .out_stall_i, .status_o,
    .expired_o, .expired_task_o, .remaining_o, .last_o
  );
endmodule

### hw/rtl/htw_checker.sv
// Port-level checker for the hashed timer wheel, bound to the top level.
// Depends on hashed_timer_wheel_assert.svh and htw_pkg.
`include "hashed_timer_wheel_assert.svh"
module htw_checker import htw_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  status_o,
  input logic        expired_o,
  input logic [31:0] remaining_o,
  input logic        last_o
);
  `HTW_ASSERT_IMP(a_exp_ok, clk_i, rst_ni, out_valid_o && expired_o, status_o == ST_OK && remaining_o == 32'd0, "expired result with status or remaining")
  `HTW_ASSERT_IMP(a_status_range, clk_i, rst_ni, out_valid_o, status_o <= ST_NOTPARKED, "bad status")
  `HTW_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "accepted two items back to back")
  `HTW_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(last_o), "stalled result changed")
endmodule

bind hashed_timer_wheel htw_checker u_htw_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .in_valid_i, .in_stall_o,
  .status_o, .expired_o, .remaining_o, .last_o
);
